// ===== sv/pla_pkg.sv =====
// Shared types, constants and the arctangent lookup function for the polyline length accumulator.
package pla_pkg;

    localparam int unsigned COORD_WIDTH  = 32;
    localparam int unsigned OUT_WIDTH    = 48;
    localparam int unsigned CORDIC_STEPS = 30;
    localparam int unsigned RED_STEPS    = 8;
    localparam int unsigned STEP_BITS    = 5;
    localparam int unsigned Q_WIDTH      = 34;
    localparam int unsigned DEG_TO_RAD   = 18740330;
    localparam int unsigned CORDIC_GAIN  = 652032874;
    localparam int unsigned EARTH_R2     = 12756274;

    typedef enum logic [2:0] {
        AS_LAT  = 3'b001,
        AS_LON  = 3'b010,
        AS_LAT1 = 3'b100
    } t_angle_sel;

    typedef enum logic [3:0] {
        OP_NONE   = 4'h0,
        OP_LOAD   = 4'h1,
        OP_PSQ    = 4'h2,
        OP_PSQRT  = 4'h3,
        OP_COS    = 4'h4,
        OP_COSIT  = 4'h5,
        OP_COSEND = 4'h6,
        OP_HAV    = 4'h7,
        OP_SQRT   = 4'h8,
        OP_ATAN   = 4'h9,
        OP_ATIT   = 4'hA,
        OP_DIST   = 4'hB,
        OP_ACC    = 4'hC,
        OP_CLEAR  = 4'hD,
        OP_MUL    = 4'hE,
        OP_RED    = 4'hF
    } t_op;

    typedef struct packed {
        t_op        op;
        t_angle_sel sel;
        logic [1:0] slot;
        logic       flag;
    } t_cmd;

    typedef struct packed {
        logic iter_done;
    } t_status;

    function automatic logic signed [Q_WIDTH-1:0] atan_q30(input logic [STEP_BITS-1:0] i);
        logic signed [Q_WIDTH-1:0] v;
        begin
            case (i)
                5'd0: v = 34'sd843314857;
                5'd1: v = 34'sd497837829;
                5'd2: v = 34'sd263043837;
                5'd3: v = 34'sd133525159;
                5'd4: v = 34'sd67021687;
                5'd5: v = 34'sd33543516;
                5'd6: v = 34'sd16775851;
                5'd7: v = 34'sd8388437;
                5'd8: v = 34'sd4194283;
                5'd9: v = 34'sd2097149;
                5'd10: v = 34'sd1048575;
                default: v = Q_WIDTH'(34'sd1) <<< (30 - i);
            endcase
            return v;
        end
    endfunction

endpackage

// ===== sv/pla_datapath.sv =====
// Datapath: vertex store, planar and haversine arithmetic and the saturating sum.
module pla_datapath
    import pla_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int SUM_WIDTH       = 48
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic                    i_geo,
    input  logic signed [31:0]      i_x,
    input  logic signed [31:0]      i_y,
    output t_status                 o_status,
    output logic                    o_have_prev,
    output logic [OUT_WIDTH-1:0]    o_total,
    output logic                    o_sat
);
    localparam logic [63:0] FULL    = 64'd360 << COORD_FRAC_BITS;
    localparam logic [63:0] HALF    = 64'd180 << COORD_FRAC_BITS;
    localparam logic [63:0] QUARTER = 64'd90 << COORD_FRAC_BITS;
    localparam logic [SUM_WIDTH-1:0] SMAX = '1;
    localparam int SHIFT = 30 - COORD_FRAC_BITS;

    logic signed [32:0] r_px, r_py, r_cx, r_cy;
    logic               r_have;
    logic [SUM_WIDTH-1:0] r_sum;
    logic               r_ovf;
    logic               r_geo;
    logic signed [Q_WIDTH-1:0] r_x, r_yv, r_z;
    logic [STEP_BITS-1:0] r_i;
    logic               r_neg;
    logic signed [Q_WIDTH-1:0] r_cos [4];
    logic [67:0]        r_n;
    logic [33:0]        r_root;
    logic [5:0]         r_sbit;
    logic [63:0]        r_seg;
    logic signed [Q_WIDTH-1:0] r_sa;
    logic signed [Q_WIDTH-1:0] r_a;
    logic signed [65:0] r_m;
    logic               r_sqsel;

    logic signed [33:0] ang;
    logic [33:0]        mag;
    logic [33:0]        r_red;
    logic [33:0]        red;
    logic [33:0]        red_step;
    logic               red_neg;
    logic signed [Q_WIDTH-1:0] xs, ys;
    logic [33:0]        t_try;
    logic [67:0]        t_sq;
    logic signed [Q_WIDTH-1:0] cx;
    logic signed [33:0] dx, dy;
    logic [31:0]        ax, ay;
    logic [63:0]        sq_x, sq_y;

    always_comb begin
        case (i_cmd.sel)
            AS_LAT:  ang = 34'(r_cy) - 34'(r_py);
            AS_LON:  ang = 34'(r_cx) - 34'(r_px);
            default: ang = i_cmd.flag ? 34'(r_cy) : 34'(r_py);
        endcase
        mag = 34'($unsigned(ang[33] ? -ang : ang));
        red_step = 34'(FULL << (3'(RED_STEPS - 1) - r_i[2:0]));
        red = r_red;
        if (64'(red) > HALF) red = 34'(FULL - 64'(red));
        red_neg = 1'b0;
        if (64'(red) > QUARTER) begin
            red_neg = 1'b1;
            red = 34'(HALF - 64'(red));
        end
        xs = r_x >>> r_i;
        ys = r_yv >>> r_i;
        t_try = r_root | (34'd1 << r_sbit);
        t_sq = 68'(t_try) * 68'(t_try);
        cx = r_x;
        if (cx < 0) cx = '0;
        if (cx > (Q_WIDTH'(1) <<< 30)) cx = Q_WIDTH'(1) <<< 30;
        dx = 34'(r_cx) - 34'(r_px);
        dy = 34'(r_cy) - 34'(r_py);
        ax = 32'($unsigned(dx[33] ? -dx : dx));
        ay = 32'($unsigned(dy[33] ? -dy : dy));
        sq_x = {32'd0, ax} * {32'd0, ax};
        sq_y = {32'd0, ay} * {32'd0, ay};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_sum  <= '0;
            r_ovf  <= 1'b0;
            r_px   <= '0;
            r_py   <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_cx <= 33'(i_x);
                    r_cy <= 33'(i_y);
                    r_geo <= i_geo;
                end
                OP_PSQ: begin
                    r_n <= 68'(sq_x) + 68'(sq_y);
                    r_root <= '0;
                    r_sbit <= 6'd33;
                end
                OP_SQRT: begin
                    r_n <= r_sqsel ? 68'(r_a) << 30
                                   : 68'((Q_WIDTH'(1) <<< 30) - r_a) << 30;
                    r_root <= '0;
                    r_sbit <= 6'd31;
                end
                OP_PSQRT: begin
                    if (t_sq <= r_n) r_root <= t_try;
                    if (r_sbit != 0) r_sbit <= r_sbit - 6'd1;
                end
                OP_COS: begin
                    r_red <= mag;
                    r_i <= '0;
                end
                OP_RED: begin
                    if (i_cmd.flag) begin
                        r_neg <= red_neg;
                        r_x <= Q_WIDTH'(CORDIC_GAIN);
                        r_yv <= '0;
                        r_z <= Q_WIDTH'((64'(red) * 64'(DEG_TO_RAD)) >> COORD_FRAC_BITS);
                        r_i <= '0;
                    end else begin
                        if (r_red >= red_step) r_red <= r_red - red_step;
                        r_i <= r_i + STEP_BITS'(1);
                    end
                end
                OP_COSIT: begin
                    if (r_z >= 0) begin
                        r_x <= r_x - ys; r_yv <= r_yv + xs; r_z <= r_z - atan_q30(r_i);
                    end else begin
                        r_x <= r_x + ys; r_yv <= r_yv - xs; r_z <= r_z + atan_q30(r_i);
                    end
                    r_i <= r_i + STEP_BITS'(1);
                end
                OP_COSEND: r_cos[i_cmd.slot] <= r_neg ? -cx : cx;
                OP_MUL: begin
                    if (i_cmd.flag)
                        r_m <= 66'(r_cos[2]) * 66'(r_cos[3]);
                    else
                        r_m <= 66'(r_sa) * 66'(((Q_WIDTH'(1) <<< 30) - r_cos[1]) >>> 1);
                end
                OP_HAV: begin
                    if (i_cmd.flag) begin
                        r_sa <= Q_WIDTH'(r_m >>> 30);
                    end else begin
                        logic signed [Q_WIDTH-1:0] av;
                        av = (((Q_WIDTH'(1) <<< 30) - r_cos[0]) >>> 1) + Q_WIDTH'(r_m >>> 30);
                        if (av < 0) av = '0;
                        if (av > (Q_WIDTH'(1) <<< 30)) av = Q_WIDTH'(1) <<< 30;
                        r_a <= av;
                        r_sqsel <= 1'b1;
                    end
                end
                OP_ATAN: begin
                    if (i_cmd.flag) begin
                        r_yv <= Q_WIDTH'(r_root);
                        r_sqsel <= 1'b0;
                    end else begin
                        r_x <= Q_WIDTH'(r_root);
                        r_z <= '0;
                        r_i <= '0;
                    end
                end
                OP_ATIT: begin
                    if (r_yv >= 0) begin
                        r_x <= r_x + ys; r_yv <= r_yv - xs; r_z <= r_z + atan_q30(r_i);
                    end else begin
                        r_x <= r_x - ys; r_yv <= r_yv + xs; r_z <= r_z - atan_q30(r_i);
                    end
                    r_i <= r_i + STEP_BITS'(1);
                end
                OP_DIST: begin
                    if (r_geo)
                        r_seg <= 64'(((r_z < 0 ? 64'd0 : 64'(r_z)) * 64'(EARTH_R2)) >> SHIFT);
                    else
                        r_seg <= 64'(r_root);
                end
                OP_ACC: begin
                    if (r_have) begin
                        if (r_seg > 64'(SMAX - r_sum)) begin
                            r_sum <= SMAX;
                            r_ovf <= 1'b1;
                        end else begin
                            r_sum <= r_sum + SUM_WIDTH'(r_seg);
                        end
                    end
                    r_px <= r_cx;
                    r_py <= r_cy;
                    r_have <= 1'b1;
                end
                OP_CLEAR: begin
                    r_have <= 1'b0;
                    r_sum  <= '0;
                    r_ovf  <= 1'b0;
                    r_px   <= '0;
                    r_py   <= '0;
                end
                default: ;
            endcase
        end
    end

    assign o_status.iter_done = (i_cmd.op == OP_PSQRT) ? (r_sbit == 0)
                              : (i_cmd.op == OP_RED) ? (r_i == STEP_BITS'(RED_STEPS - 1))
                              : (r_i == STEP_BITS'(CORDIC_STEPS - 1));
    assign o_have_prev = r_have;

    always_comb begin
        if (64'(r_sum) > 64'({OUT_WIDTH{1'b1}})) begin
            o_total = '1;
            o_sat   = 1'b1;
        end else begin
            o_total = OUT_WIDTH'(r_sum);
            o_sat   = r_ovf;
        end
    end
endmodule

// ===== sv/pla_control.sv =====
// Sequencer that steps the datapath through one vertex.
module pla_control
    import pla_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  logic    i_last,
    input  logic    i_geo,
    input  logic    i_have_prev,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_valid,
    input  logic    i_stall
);
    typedef enum logic [16:0] {
        S_IDLE   = 17'h00001, S_PSQ   = 17'h00002, S_RED   = 17'h00004,
        S_COS    = 17'h00008, S_COSIT = 17'h00010, S_COSEND = 17'h00020,
        S_MUL    = 17'h00040, S_HAV   = 17'h00080, S_SQRT  = 17'h00100,
        S_ATAN   = 17'h00200, S_ATIT  = 17'h00400, S_DIST  = 17'h00800,
        S_ACC    = 17'h01000, S_OUT   = 17'h02000, S_SQIT  = 17'h04000,
        S_ROOT   = 17'h08000, S_CINIT = 17'h10000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_slot, n_slot;
    logic [1:0] r_phase, n_phase;
    logic r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot <= '0;
            r_phase <= '0;
            r_last <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot <= n_slot;
            r_phase <= n_phase;
            r_last <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot = r_slot;
        n_phase = r_phase;
        n_last = r_last;
        o_cmd = '{op: OP_NONE, sel: AS_LAT, slot: 2'd0, flag: 1'b0};
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_last = i_last;
                    n_slot = '0;
                    n_state = !i_have_prev ? S_ACC : (i_geo ? S_COS : S_PSQ);
                end
            end
            S_PSQ: begin o_cmd.op = OP_PSQ; n_state = S_SQIT; n_phase = 2'd0; end
            S_SQIT: begin
                o_cmd.op = OP_PSQRT;
                if (i_status.iter_done) n_state = (r_phase == 2'd0) ? S_DIST : S_ROOT;
            end
            S_COS: begin
                o_cmd.op = OP_COS;
                case (r_slot)
                    2'd0: o_cmd.sel = AS_LAT;
                    2'd1: o_cmd.sel = AS_LON;
                    2'd2: begin o_cmd.sel = AS_LAT1; o_cmd.flag = 1'b0; end
                    default: begin o_cmd.sel = AS_LAT1; o_cmd.flag = 1'b1; end
                endcase
                n_state = S_RED;
            end
            S_RED: begin
                o_cmd.op = OP_RED;
                if (i_status.iter_done) n_state = S_CINIT;
            end
            S_CINIT: begin
                o_cmd.op = OP_RED;
                o_cmd.flag = 1'b1;
                n_state = S_COSIT;
            end
            S_COSIT: begin
                o_cmd.op = OP_COSIT;
                if (i_status.iter_done) n_state = S_COSEND;
            end
            S_COSEND: begin
                o_cmd.op = OP_COSEND;
                o_cmd.slot = r_slot;
                n_slot = r_slot + 2'd1;
                n_phase = 2'd0;
                n_state = (r_slot == 2'd3) ? S_MUL : S_COS;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                o_cmd.flag = (r_phase == 2'd0);
                n_state = S_HAV;
            end
            S_HAV: begin
                o_cmd.op = OP_HAV;
                o_cmd.flag = (r_phase == 2'd0);
                n_phase = r_phase + 2'd1;
                n_state = (r_phase == 2'd0) ? S_MUL : S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                n_phase = 2'd1;
                n_state = S_SQIT;
            end
            S_ROOT: begin
                o_cmd.op = OP_ATAN;
                o_cmd.flag = !r_slot[0];
                if (!r_slot[0]) begin
                    n_slot = 2'd1;
                    n_state = S_SQRT;
                end else begin
                    n_state = S_ATAN;
                end
            end
            S_ATAN: begin o_cmd.op = OP_ATAN; o_cmd.flag = 1'b0; n_state = S_ATIT; end
            S_ATIT: begin
                o_cmd.op = OP_ATIT;
                if (i_status.iter_done) n_state = S_DIST;
            end
            S_DIST: begin o_cmd.op = OP_DIST; n_state = S_ACC; end
            S_ACC: begin
                o_cmd.op = OP_ACC;
                n_state = r_last ? S_OUT : S_IDLE;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    o_cmd.op = OP_CLEAR;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ===== sv/polyline_length_accumulator.sv =====
// Top level of the polyline length accumulator.
// Vertices arrive as beats on the input channel (i_valid, o_stall) with
// signed fixed-point x and y and a last-vertex flag. Each beat after the first
// of a line adds the planar or haversine segment length to a running sum.
// On the last vertex the total appears as one beat on the output channel
// (o_valid, i_stall) and the block clears itself for the next line.
// A planar vertex runs the 34-step bit-serial square root.
// A geodesic vertex runs four cosine passes (each an 8-step modulo-360
// reduction and a 30-step CORDIC), two 32-step square roots and one 30-step
// arctangent CORDIC on one shared datapath.
// A first vertex is only loaded and kept as the previous vertex. A last vertex
// also gives the result beat.
// One vertex is in work at a time; o_stall is low only when the block waits.
// A result beat holds while i_stall is high and no new vertex is taken.
// Reset clears the sum, the previous vertex and geodesic mode.
// Geodesic mode is written from i_cfg_data when i_cfg_we is high and applies to later segments.
module polyline_length_accumulator
    import pla_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 16,
    parameter int SUM_WIDTH       = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_x_coord,
    input  logic signed [31:0]   i_y_coord,
    input  logic                 i_last_point,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [OUT_WIDTH-1:0] o_total_length,
    output logic                 o_length_saturated
);
    logic    r_geo;
    t_cmd    cmd;
    t_status status;
    logic    have_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geo <= 1'b0;
        end else if (i_cfg_we) begin
            r_geo <= i_cfg_data;
        end
    end

    pla_control u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall,
        .i_last(i_last_point), .i_geo(r_geo), .i_have_prev(have_prev),
        .i_status(status), .o_cmd(cmd), .o_valid, .i_stall
    );

    pla_datapath #(.COORD_FRAC_BITS(COORD_FRAC_BITS), .SUM_WIDTH(SUM_WIDTH)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_geo(r_geo),
        .i_x(i_x_coord), .i_y(i_y_coord), .o_status(status),
        .o_have_prev(have_prev), .o_total(o_total_length), .o_sat(o_length_saturated)
    );
endmodule

// ===== bench/polyline_length_accumulator_checker.sv =====
// Checker for the polyline length accumulator: predicts line totals and compares result beats.
`timescale 1ns / 100ps
module polyline_length_accumulator_checker
    import pla_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic signed [31:0]   i_x_coord,
    input  logic signed [31:0]   i_y_coord,
    input  logic                 i_last_point,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [OUT_WIDTH-1:0] i_total_length,
    input  logic                 i_length_saturated,
    output int                   o_errors,
    output int                   o_pending
);

    localparam longint Q30_ONE = 64'sd1 << 30;
    localparam longint SUM_MAX = (64'sd1 << 48) - 1;

    typedef struct {
        logic [OUT_WIDTH-1:0] total;
        logic                 sat;
    } t_line_total;

    const longint atan_steps[30] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048575, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2
    };

    t_line_total line_totals[$];
    logic        geo_mode;
    longint      last_x;
    longint      last_y;
    logic        vertex_seen;
    longint      length_sum;
    logic        clamped;

    function automatic longint planar_len(longint dx, longint dy);
        logic [67:0] ax;
        logic [67:0] ay;
        logic [67:0] norm;
        logic [67:0] r;
        logic [67:0] t;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        norm = ax * ax + ay * ay;
        r = 0;
        for (int b = 33; b >= 0; b--) begin
            t = r | (68'd1 << b);
            if (t * t <= norm) r = t;
        end
        return longint'(r);
    endfunction

    function automatic longint root_q30(longint unsigned n);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= n) r = t;
        end
        return longint'(r);
    endfunction

    function automatic longint cos_q30(longint deg);
        longint full;
        longint half;
        longint quarter;
        longint r;
        longint cx;
        longint cy;
        longint z;
        longint xs;
        longint ys;
        logic   flip;
        full = 64'sd360 << 16;
        half = 64'sd180 << 16;
        quarter = 64'sd90 << 16;
        r = deg % full;
        flip = 1'b0;
        cx = CORDIC_GAIN;
        cy = 0;
        if (r < 0) r += full;
        if (r > half) r = full - r;
        if (r > quarter) begin
            flip = 1'b1;
            r = half - r;
        end
        z = (r * DEG_TO_RAD) >>> 16;
        for (int i = 0; i < 30; i++) begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0) begin
                cx -= ys; cy += xs; z -= atan_steps[i];
            end else begin
                cx += ys; cy -= xs; z += atan_steps[i];
            end
        end
        if (cx < 0) cx = 0;
        if (cx > Q30_ONE) cx = Q30_ONE;
        return flip ? -cx : cx;
    endfunction

    function automatic longint great_circle_len(longint lon1, longint lat1,
                                                longint lon2, longint lat2);
        longint hlat;
        longint hlon;
        longint a;
        longint vx;
        longint vy;
        longint z;
        longint xs;
        longint ys;
        hlat = (Q30_ONE - cos_q30(lat2 - lat1)) >>> 1;
        hlon = (Q30_ONE - cos_q30(lon2 - lon1)) >>> 1;
        a = hlat + ((((cos_q30(lat1) * cos_q30(lat2)) >>> 30) * hlon) >>> 30);
        if (a < 0) a = 0;
        if (a > Q30_ONE) a = Q30_ONE;
        vy = root_q30(a << 30);
        vx = root_q30((Q30_ONE - a) << 30);
        z = 0;
        for (int i = 0; i < 30; i++) begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy >= 0) begin
                vx += ys; vy -= xs; z += atan_steps[i];
            end else begin
                vx -= ys; vy += xs; z -= atan_steps[i];
            end
        end
        if (z < 0) z = 0;
        return (z * 2 * 6378137) >>> 14;
    endfunction

    assign o_pending = line_totals.size();

    always @(posedge i_clk) begin
        longint      nx;
        longint      ny;
        longint      seg;
        t_line_total want;
        int          fails;
        if (!i_rst_n) begin
            geo_mode <= 1'b0;
            last_x = 0;
            last_y = 0;
            vertex_seen = 1'b0;
            length_sum = 0;
            clamped = 1'b0;
            o_errors <= 0;
        end else begin
            fails = 0;
            if (i_cfg_we) geo_mode <= i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                nx = i_x_coord;
                ny = i_y_coord;
                if (vertex_seen) begin
                    seg = geo_mode ? great_circle_len(last_x, last_y, nx, ny)
                                   : planar_len(nx - last_x, ny - last_y);
                    if (seg > SUM_MAX - length_sum) begin
                        length_sum = SUM_MAX;
                        clamped = 1'b1;
                    end else begin
                        length_sum += seg;
                    end
                end
                last_x = nx;
                last_y = ny;
                vertex_seen = 1'b1;
                if (i_last_point) begin
                    want.total = length_sum[OUT_WIDTH-1:0];
                    want.sat = clamped;
                    line_totals = {line_totals, want};
                    vertex_seen = 1'b0;
                    last_x = 0;
                    last_y = 0;
                    length_sum = 0;
                    clamped = 1'b0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (line_totals.size() == 0) begin
                    $display("%0t: unexpected result beat, length %0d saturated %0b",
                             $time, i_total_length, i_length_saturated);
                    fails++;
                end else begin
                    want = line_totals.pop_front();
                    if (want.total !== i_total_length) begin
                        $display("%0t: total_length expected %0d actual %0d",
                                 $time, want.total, i_total_length);
                        fails++;
                    end
                    if (want.sat !== i_length_saturated) begin
                        $display("%0t: length_saturated expected %0b actual %0b",
                                 $time, want.sat, i_length_saturated);
                        fails++;
                    end
                end
            end
            o_errors <= o_errors + fails;
        end
    end

endmodule

// ===== bench/polyline_length_accumulator_tb.sv =====
// Testbench top for the polyline length accumulator: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps
module polyline_length_accumulator_tb;
    import pla_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int DEG = 65536;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_data = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic signed [31:0]   i_x_coord = '0;
    logic signed [31:0]   i_y_coord = '0;
    logic                 i_last_point = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [OUT_WIDTH-1:0] o_total_length;
    logic                 o_length_saturated;
    int                   errors;
    int                   pending;
    int                   idle_pct = 31;
    int                   quiet_cycles = 0;
    logic signed [31:0]   prev_x = '0;
    logic signed [31:0]   prev_y = '0;

    always #2 i_clk = ~i_clk;

    polyline_length_accumulator dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_x_coord          (i_x_coord),
        .i_y_coord          (i_y_coord),
        .i_last_point       (i_last_point),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_total_length     (o_total_length),
        .o_length_saturated (o_length_saturated)
    );

    polyline_length_accumulator_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_x_coord          (i_x_coord),
        .i_y_coord          (i_y_coord),
        .i_last_point       (i_last_point),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_total_length     (o_total_length),
        .i_length_saturated (o_length_saturated),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                               input logic last);
        if ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_valid <= 1'b1;
        i_x_coord <= x;
        i_y_coord <= y;
        i_last_point <= last;
        prev_x = x;
        prev_y = y;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic set_mode(input logic geo);
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= geo;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] near,
                                                      input int span_deg);
        case ($urandom_range(4))
            0: return $urandom;
            1: return near + $signed($urandom_range(2 * DEG)) - DEG;
            2: return $signed($urandom_range(2 * span_deg * DEG)) - span_deg * DEG;
            3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return near + $signed($urandom_range(64)) - 32;
        endcase
    endfunction

    task automatic random_lines(input int count, input logic geo);
        int left;
        int len;
        left = count;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
            for (int k = 1; k <= len; k++) begin
                send_vertex(pick_coord(prev_x, geo ? 180 : 30000),
                            pick_coord(prev_y, geo ? 90 : 30000), k == len);
                left--;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_vertex(32'sd5, 32'sd7, 1'b1);
        send_vertex(32'sh80000000, 32'sh80000000, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh7fffffff, 1'b0);
        send_vertex(32'sh80000000, 32'sh7fffffff, 1'b1);
        send_vertex(32'sd0, 32'sd0, 1'b0);
        send_vertex(32'sd3 * DEG, 32'sd4 * DEG, 1'b0);
        send_vertex(32'sd3 * DEG, 32'sd4 * DEG, 1'b0);

        set_mode(1'b1);
        send_vertex(32'sd10 * DEG, 32'sd10 * DEG, 1'b1);
        send_vertex(32'sd0, 32'sd0, 1'b0);
        send_vertex(32'sd180 * DEG, 32'sd0, 1'b0);
        send_vertex(-32'sd180 * DEG, 32'sd90 * DEG, 1'b0);
        send_vertex(32'sd1000 * DEG, -32'sd90 * DEG, 1'b0);
        send_vertex(32'sd1000 * DEG, -32'sd90 * DEG, 1'b0);
        send_vertex(32'sh7fffffff, 32'sh80000000, 1'b1);
        send_vertex(32'sd0, 32'sd0, 1'b1);
        for (int k = 0; k < 240; k++)
            send_vertex((k % 2) ? 32'sd180 * DEG : 32'sd0, 32'sd0, k == 239);

        set_mode(1'b0);
        idle_pct = 0;
        random_lines(150, 1'b0);
        idle_pct = 31;
        random_lines(450, 1'b0);
        set_mode(1'b1);
        random_lines(500, 1'b1);
        set_mode(1'b0);
        random_lines(450, 1'b0);
        set_mode(1'b1);
        random_lines(450, 1'b1);
        send_vertex(32'sd1 * DEG, 32'sd2 * DEG, 1'b1);

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/pla_pkg.sv
sv/pla_datapath.sv
sv/pla_control.sv
sv/polyline_length_accumulator.sv
bench/polyline_length_accumulator_checker.sv
bench/polyline_length_accumulator_tb.sv
